>>> rtl/shbs_pkg.sv
// Package for the string hash bucket select block: constants, codes and link types.
`timescale 1ns / 1ps
`default_nettype none

package shbs_pkg;

	// Field and register widths
	localparam int CHAR_W     = 7;
	localparam int BUCKET_W   = 16;
	localparam int FULL_W     = 64;
	localparam int IN_DATA_W  = 8;
	localparam int OUT_DATA_W = BUCKET_W + FULL_W;
	localparam int MODE_W     = 2;
	localparam int COUNT_W    = 17;
	localparam int CFG_DATA_W = COUNT_W;
	localparam int REG_IDX_W  = 1;

	// Hash defaults and constants
	localparam int HASH_BITS_DEF = 64;
	localparam int SUM_BITS      = 32;
	localparam logic [31:0] DJB2_SEED = 32'd5381;
	localparam logic [COUNT_W-1:0] MAX_BUCKETS = 17'd65536;
	localparam logic [COUNT_W-1:0] MIN_BUCKETS = 17'd1;

	// Register indexes on the configuration port
	localparam logic [REG_IDX_W-1:0] REG_HASH_MODE    = 1'b0;
	localparam logic [REG_IDX_W-1:0] REG_BUCKET_COUNT = 1'b1;

	// Hash modes
	typedef enum logic [MODE_W-1:0] {
		MODE_SUM  = 2'd0,
		MODE_LSB  = 2'd1,
		MODE_DJB2 = 2'd2,
		MODE_SDBM = 2'd3
	} mode_t;

	// Controller to datapath commands
	typedef struct packed {
		logic accept;    // input transfer: apply the character
		logic start;     // last character: load dividend and divisor
		logic div_step;  // one restoring-division step
		logic out_load;  // capture result in output register
	} cmd_t;

	// Datapath status
	typedef struct packed {
		logic               mid_string;
		logic [COUNT_W-1:0] divisor;
	} sts_t;

endpackage

`default_nettype wire

>>> rtl/shbs_ctrl.sv
// Controller for the string hash block: run/divide state machine and output valid.
`timescale 1ns / 1ps
`default_nettype none

module shbs_ctrl #(
	parameter int HASH_BITS = shbs_pkg::HASH_BITS_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          s_tvalid,
	input  wire logic          s_tlast,
	output logic               s_tready,
	output logic               m_tvalid,
	input  wire logic          m_tready,
	output shbs_pkg::cmd_t     cmd
);

	localparam int CNT_W = $clog2(HASH_BITS);

	typedef enum logic [1:0] {
		S_RUN = 2'b01,
		S_DIV = 2'b10
	} state_t;

	state_t           state_q, state_d;
	logic [CNT_W-1:0] cnt_q;
	logic             out_valid_q;
	logic             out_free;
	logic             cnt_zero;

	assign s_tready = (state_q == S_RUN);
	assign m_tvalid = out_valid_q;
	assign out_free = !out_valid_q || m_tready;
	assign cnt_zero = (cnt_q == '0);

	// Command decode
	always_comb begin
		cmd.accept   = s_tready && s_tvalid;
		cmd.start    = s_tready && s_tvalid && s_tlast;
		cmd.div_step = (state_q == S_DIV) && (!cnt_zero || out_free);
		cmd.out_load = (state_q == S_DIV) && cnt_zero && out_free;
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_RUN: begin
				if (cmd.start) state_d = S_DIV;
			end
			S_DIV: begin
				if (cmd.out_load) state_d = S_RUN;
			end
			default: state_d = S_RUN;
		endcase
	end

	// State, step counter and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_RUN;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.start)
				cnt_q <= CNT_W'(HASH_BITS - 1);
			else if (cmd.div_step && !cnt_zero)
				cnt_q <= cnt_q - 1'b1;
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;
		end
	end

endmodule

`default_nettype wire

>>> rtl/shbs_dp.sv
// Datapath for the string hash block: config registers, hash update, serial modulo.
`timescale 1ns / 1ps
`default_nettype none

module shbs_dp #(
	parameter int HASH_BITS = shbs_pkg::HASH_BITS_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic [shbs_pkg::REG_IDX_W-1:0]    cfg_addr,
	input  wire logic [shbs_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  wire logic [shbs_pkg::CHAR_W-1:0]       char_code,
	input  wire shbs_pkg::cmd_t                    cmd,
	output shbs_pkg::sts_t                         sts,
	output logic [shbs_pkg::BUCKET_W-1:0]          bucket_index,
	output logic [shbs_pkg::FULL_W-1:0]            full_hash
);

	localparam int CW = shbs_pkg::COUNT_W;

	shbs_pkg::mode_t      mode_q;
	logic [CW-1:0]        bucket_count_q;
	logic [HASH_BITS-1:0] hash_q;
	logic                 mid_q;
	logic [HASH_BITS-1:0] dividend_q;
	logic [CW-1:0]        rem_q;
	logic [CW-1:0]        divisor_q;
	logic [shbs_pkg::BUCKET_W-1:0] bucket_q;
	logic [HASH_BITS-1:0] full_q;

	logic [HASH_BITS-1:0] base;
	logic [HASH_BITS-1:0] hash_d;
	logic [HASH_BITS-1:0] c_ext;
	logic [shbs_pkg::SUM_BITS-1:0] sum_d;
	logic [CW-1:0]        divisor_eff;
	logic [CW:0]          rem_trial;
	logic [CW:0]          rem_sub;
	logic [CW-1:0]        rem_next;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q         <= shbs_pkg::MODE_SDBM;
			bucket_count_q <= shbs_pkg::MIN_BUCKETS;
		end else if (cfg_we) begin
			case (cfg_addr)
				shbs_pkg::REG_HASH_MODE:
					mode_q <= shbs_pkg::mode_t'(cfg_data[shbs_pkg::MODE_W-1:0]);
				shbs_pkg::REG_BUCKET_COUNT:
					bucket_count_q <= cfg_data[CW-1:0];
				default: ;
			endcase
		end
	end

	// Hash update: start value at string start, then one character
	assign c_ext = HASH_BITS'(char_code);

	always_comb begin
		if (mid_q)
			base = hash_q;
		else if (mode_q == shbs_pkg::MODE_DJB2)
			base = HASH_BITS'(shbs_pkg::DJB2_SEED);
		else
			base = '0;
		sum_d  = '0;
		hash_d = '0;
		case (mode_q)
			shbs_pkg::MODE_SUM: begin
				sum_d  = base[shbs_pkg::SUM_BITS-1:0] + shbs_pkg::SUM_BITS'(char_code);
				hash_d = HASH_BITS'(sum_d);
			end
			shbs_pkg::MODE_LSB: begin
				sum_d  = base[shbs_pkg::SUM_BITS-1:0] + shbs_pkg::SUM_BITS'(char_code[0]);
				hash_d = HASH_BITS'(sum_d);
			end
			shbs_pkg::MODE_DJB2:
				hash_d = (base << 5) + base + c_ext;
			shbs_pkg::MODE_SDBM:
				hash_d = (base << 6) + (base << 16) - base + c_ext;
			default: hash_d = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_q <= '0;
			mid_q  <= 1'b0;
		end else if (cmd.accept) begin
			hash_q <= hash_d;
			mid_q  <= !cmd.start;
		end
	end

	// Bucket count clamped to 1..65536
	always_comb begin
		if (bucket_count_q == '0)
			divisor_eff = shbs_pkg::MIN_BUCKETS;
		else if (bucket_count_q > shbs_pkg::MAX_BUCKETS)
			divisor_eff = shbs_pkg::MAX_BUCKETS;
		else
			divisor_eff = bucket_count_q;
	end

	// Restoring modulo, one dividend bit per step, MSB first
	assign rem_trial = {rem_q, dividend_q[HASH_BITS-1]};
	assign rem_sub   = rem_trial - {1'b0, divisor_q};
	assign rem_next  = (rem_trial >= {1'b0, divisor_q}) ? rem_sub[CW-1:0] : rem_trial[CW-1:0];

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			dividend_q <= hash_d;
			rem_q      <= '0;
			divisor_q  <= divisor_eff;
		end else if (cmd.div_step) begin
			dividend_q <= {dividend_q[HASH_BITS-2:0], 1'b0};
			rem_q      <= rem_next;
		end
	end

	// Output register: remainder and the hash it came from
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			bucket_q <= rem_next[shbs_pkg::BUCKET_W-1:0];
			full_q   <= hash_q;
		end
	end

	assign bucket_index   = bucket_q;
	assign full_hash      = shbs_pkg::FULL_W'(full_q);
	assign sts.mid_string = mid_q;
	assign sts.divisor    = divisor_q;

endmodule

`default_nettype wire

>>> rtl/string_hash_bucket_select.sv
// A character that is not the last is taken and applied to the hash. After the transfer of
// the last character, the serial modulo unit retires one hash bit per cycle and then raises
// m_tvalid, its final step waiting while the previous result is untaken. Characters are taken
// one per cycle while no modulo runs; a string end holds the input until its result is loaded.
// Reset (arst_n, asynchronous, active low): mode sdbm, one bucket, no string in progress,
// no result pending.
`timescale 1ns / 1ps
`default_nettype none

module string_hash_bucket_select #(
	parameter int HASH_BITS = shbs_pkg::HASH_BITS_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_we,
	input  wire logic [shbs_pkg::REG_IDX_W-1:0]      cfg_addr,
	input  wire logic [shbs_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  wire logic                                s_tvalid,
	output logic                                     s_tready,
	input  wire logic [shbs_pkg::IN_DATA_W-1:0]      s_tdata,  // [6:0] char_code, [7] zero
	input  wire logic                                s_tlast,  // last_char
	output logic                                     m_tvalid,
	input  wire logic                                m_tready,
	output logic [shbs_pkg::OUT_DATA_W-1:0]          m_tdata   // [15:0] bucket_index, [79:16] full_hash
);

	shbs_pkg::cmd_t cmd;
	shbs_pkg::sts_t sts;
	logic [shbs_pkg::BUCKET_W-1:0] bucket_index;
	logic [shbs_pkg::FULL_W-1:0]   full_hash;

	// Controller
	shbs_ctrl #(
		.HASH_BITS(HASH_BITS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tlast  (s_tlast),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd)
	);

	// Datapath
	shbs_dp #(
		.HASH_BITS(HASH_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_addr     (cfg_addr),
		.cfg_data     (cfg_data),
		.char_code    (s_tdata[shbs_pkg::CHAR_W-1:0]),
		.cmd          (cmd),
		.sts          (sts),
		.bucket_index (bucket_index),
		.full_hash    (full_hash)
	);

	assign m_tdata = {full_hash, bucket_index};

	// Checks
	// a result never overwrites one that has not been transferred
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!m_tvalid || m_tready))
		else $error("result register overwritten while pending");

	// a last character stops input until its modulo is done and the string is closed
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start |=> (!s_tready && !sts.mid_string))
		else $error("input open or string still open after last character");

	// the bucket index is below the divisor it was reduced by
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> ({1'b0, m_tdata[shbs_pkg::BUCKET_W-1:0]} < sts.divisor))
		else $error("bucket index not below bucket count");

endmodule

`default_nettype wire
